// ----- design/listing_gap_tracker_core_assert.svh -----
// Assertion macros shared by the listing gap tracker modules.
`ifndef LISTING_GAP_TRACKER_CORE_ASSERT_SVH
`define LISTING_GAP_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LGT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lgt_pkg.sv -----
// Shared types and constants of the listing gap tracker.
package lgt_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ENTRY = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_REQUEST  = 3'd1,
        ACT_COMPLETE = 3'd2,
        ACT_GAVE_UP  = 3'd3,
        ACT_ABORTED  = 3'd4
    } t_action;

    typedef enum logic {
        REG_QUIET_TICKS  = 1'b0,
        REG_MAX_ATTEMPTS = 1'b1
    } t_reg;

    localparam int          REG_AW       = 3;
    localparam int          REG_IDX_LSB  = 2;
    localparam logic [15:0] QUIET_RESET  = 16'd3000;
    localparam logic [3:0]  ATT_RESET    = 4'd4;
    localparam logic [15:0] QUIET_SAT    = 16'hFFFF;

    typedef struct packed {
        logic [15:0] quiet_ticks;
        logic [3:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [15:0] lo;
        logic [15:0] last;
    } t_scan_req;

    typedef struct packed {
        logic        done;
        logic        found;
        logic [15:0] gap;
    } t_scan_res;

endpackage

// ----- design/listing_gap_tracker_core.sv -----
// Listing gap tracker top level: control sequencer around the presence-map RAM.
//
// Input channel (i_valid/o_ready) takes one request: op start, entry, tick or stop,
// with the entry id, offered count and offered last id. Every request yields exactly
// one result on the output channel (o_valid/i_ready): action, request start id and
// attempts used so far. Registers quiet_ticks (0x0) and max_attempts (0x4) sit on
// the APB port; write them only while no request is in flight.
// The presence map is a RAM of ID_SPACE bits in 64-bit words (16-bit below 64 ids),
// 1024 words by default, one port, read data registered. Steps per request:
//   start: one clearing sweep of the map, then the result.
//   entry: read and write of the entry's map word if the count is nonzero and the id
//          in range, then a check; a consistent window adds a scan of one word per cycle.
//   tick on timeout: a check, plus the same scan when the window is consistent, then
//          a retry or give-up; other ticks, stops and entries while idle go to the result.
// After reset the block sweeps the whole map to zero with o_ready low;
// configuration writes are taken meanwhile.
// The result sits in an output register: the next request is accepted while it waits,
// and a stalled receiver holds that request's result in the sequencer until it drains.
module listing_gap_tracker_core #(
    parameter int ID_SPACE = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [15:0]                i_entry_id,
    input  logic [15:0]                i_offered_count,
    input  logic [15:0]                i_offered_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_action,
    output logic [15:0]                o_request_start,
    output logic [3:0]                 o_attempts_used,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lgt_pkg::REG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lgt_pkg::*;

    localparam int            WORD_W    = (ID_SPACE >= 64) ? 64 : 16;
    localparam int            WSH       = $clog2(WORD_W);
    localparam int            DEPTH     = (ID_SPACE + WORD_W - 1) / WORD_W;
    localparam int            AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0]   ID_LIM    = 17'(ID_SPACE);
    localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_MARK_RD = 8'b0000_0100,
        S_MARK_WR = 8'b0000_1000,
        S_CHECK   = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_RETRY   = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_emit, n_clr_emit;
    logic          r_tick_mode, n_tick_mode;
    logic [15:0]   r_eid, n_eid;
    logic [15:0]   r_held_count, n_held_count;
    logic [15:0]   r_held_last, n_held_last;
    logic          r_got_any, n_got_any;
    logic          r_running, n_running;
    logic [3:0]    r_attempts, n_attempts;
    logic [15:0]   r_quiet, n_quiet;
    logic [15:0]   r_retry_from, n_retry_from;
    t_action       r_act, n_act;
    logic [15:0]   r_start, n_start;
    logic          r_out_valid, n_out_valid;
    t_action       r_out_action;
    logic [15:0]   r_out_start;
    logic [3:0]    r_out_attempts;

    t_cfg              cfg;
    t_scan_req         scan_req;
    t_scan_res         scan_res;
    logic              scan_rd_en;
    logic [AW-1:0]     scan_rd_addr;
    logic              ram_en, ram_we;
    logic [AW-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [15:0]       lim_q, q_inc, win_lo, eid_w16;
    logic [3:0]        lim_a;
    logic              win_ok, out_free, id_ok;
    logic [AW-1:0]     eid_word;
    logic [WSH-1:0]    eid_bit;
    logic [16:0]       last_p1;

    lgt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lgt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    lgt_gap_scan #(
        .ID_SPACE (ID_SPACE),
        .WORD_W   (WORD_W),
        .DEPTH    (DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (scan_req),
        .i_rd_data (ram_rdata),
        .o_rd_en   (scan_rd_en),
        .o_rd_addr (scan_rd_addr),
        .o_res     (scan_res)
    );

    assign lim_q    = (cfg.quiet_ticks == 16'd0) ? 16'd1 : cfg.quiet_ticks;
    assign lim_a    = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
    assign q_inc    = (r_quiet == QUIET_SAT) ? r_quiet : r_quiet + 16'd1;
    assign last_p1  = {1'b0, r_held_last} + 17'd1;
    assign win_ok   = r_got_any && (r_held_count != 16'd0) && (last_p1 >= {1'b0, r_held_count});
    assign win_lo   = 16'(last_p1 - {1'b0, r_held_count});
    assign out_free = !r_out_valid || i_ready;
    assign id_ok    = {1'b0, i_entry_id} < ID_LIM;
    assign eid_w16  = r_eid >> WSH;
    assign eid_word = eid_w16[AW-1:0];
    assign eid_bit  = r_eid[WSH-1:0];

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_clr_emit   = r_clr_emit;
        n_tick_mode  = r_tick_mode;
        n_eid        = r_eid;
        n_held_count = r_held_count;
        n_held_last  = r_held_last;
        n_got_any    = r_got_any;
        n_running    = r_running;
        n_attempts   = r_attempts;
        n_quiet      = r_quiet;
        n_retry_from = r_retry_from;
        n_act        = r_act;
        n_start      = r_start;
        n_out_valid  = r_out_valid && !i_ready;
        scan_req.start = 1'b0;
        scan_req.lo    = win_lo;
        scan_req.last  = r_held_last;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_clr_addr;
        ram_wdata = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (r_clr_addr == LAST_WORD) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_emit ? S_EMIT : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_eid   = i_entry_id;
                    n_act   = ACT_NONE;
                    n_start = 16'd0;
                    n_state = S_EMIT;
                    unique case (t_op'(i_op))
                        OP_START: begin
                            n_held_count = 16'd0;
                            n_held_last  = 16'd0;
                            n_got_any    = 1'b0;
                            n_running    = 1'b1;
                            n_attempts   = 4'd1;
                            n_quiet      = 16'd0;
                            n_retry_from = 16'd0;
                            n_act        = ACT_REQUEST;
                            n_clr_emit   = 1'b1;
                            n_clr_addr   = '0;
                            n_state      = S_CLEAR;
                        end
                        OP_ENTRY: begin
                            if (r_running) begin
                                n_held_count = i_offered_count;
                                n_held_last  = i_offered_last;
                                n_got_any    = 1'b1;
                                n_quiet      = 16'd0;
                                n_tick_mode  = 1'b0;
                                n_state = ((i_offered_count != 16'd0) && id_ok) ? S_MARK_RD
                                                                                 : S_CHECK;
                            end
                        end
                        OP_TICK: begin
                            if (r_running) begin
                                n_quiet = q_inc;
                                if (q_inc >= lim_q) begin
                                    n_tick_mode = 1'b1;
                                    n_state     = S_CHECK;
                                end
                            end
                        end
                        OP_STOP: begin
                            if (r_running) begin
                                n_running = 1'b0;
                                n_act     = ACT_ABORTED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MARK_RD: begin
                ram_en   = 1'b1;
                ram_addr = eid_word;
                n_state  = S_MARK_WR;
            end
            S_MARK_WR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = eid_word;
                ram_wdata = ram_rdata | (WORD_W'(1) << eid_bit);
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (r_tick_mode) begin
                    if (win_ok) begin
                        scan_req.start = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        n_state = S_RETRY;
                    end
                end else if (r_held_count == 16'd0) begin
                    n_running = 1'b0;
                    n_act     = ACT_COMPLETE;
                    n_state   = S_EMIT;
                end else if (!win_ok) begin
                    n_state = S_EMIT;
                end else begin
                    scan_req.start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_en   = scan_rd_en;
                ram_addr = scan_rd_addr;
                if (scan_res.done) begin
                    if (r_tick_mode) begin
                        if (scan_res.found) begin
                            n_retry_from = scan_res.gap;
                        end
                        n_state = S_RETRY;
                    end else begin
                        if (!scan_res.found) begin
                            n_running = 1'b0;
                            n_act     = ACT_COMPLETE;
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_RETRY: begin
                if (r_attempts < lim_a) begin
                    n_attempts = r_attempts + 4'd1;
                    n_quiet    = 16'd0;
                    n_act      = ACT_REQUEST;
                    n_start    = r_retry_from;
                end else begin
                    n_running = 1'b0;
                    n_act     = ACT_GAVE_UP;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_emit   <= 1'b0;
            r_tick_mode  <= 1'b0;
            r_held_count <= 16'd0;
            r_held_last  <= 16'd0;
            r_got_any    <= 1'b0;
            r_running    <= 1'b0;
            r_attempts   <= 4'd0;
            r_quiet      <= 16'd0;
            r_retry_from <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_emit   <= n_clr_emit;
            r_tick_mode  <= n_tick_mode;
            r_held_count <= n_held_count;
            r_held_last  <= n_held_last;
            r_got_any    <= n_got_any;
            r_running    <= n_running;
            r_attempts   <= n_attempts;
            r_quiet      <= n_quiet;
            r_retry_from <= n_retry_from;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eid   <= n_eid;
        r_act   <= n_act;
        r_start <= n_start;
        if (r_state == S_EMIT && out_free) begin
            r_out_action   <= r_act;
            r_out_start    <= r_start;
            r_out_attempts <= r_attempts;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_action        = r_out_action;
    assign o_request_start = r_out_start;
    assign o_attempts_used = r_out_attempts;

`include "listing_gap_tracker_core_assert.svh"

    `LGT_ASSERT_IMPL(a_ram_wr_state, ram_we,
        (r_state == S_CLEAR) || (r_state == S_MARK_WR), "map written outside clear or mark")
    `LGT_ASSERT_IMPL(a_run_attempts, r_running, r_attempts != 4'd0,
        "running with no request sent")
    `LGT_ASSERT_NEXT(a_req_running, (r_state == S_EMIT) && out_free && (r_act == ACT_REQUEST),
        r_running && o_valid && (o_action == ACT_REQUEST), "request result without a run")

endmodule

// ----- design/lgt_ram.sv -----
// Generic single-port RAM with registered read data.
module lgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lgt_cfg.sv -----
// APB configuration registers: quiet tick limit and attempt limit.
module lgt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lgt_pkg::REG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output lgt_pkg::t_cfg             o_cfg
);
    import lgt_pkg::*;

    logic [15:0] r_quiet_ticks;
    logic [3:0]  r_max_attempts;
    logic        wr;
    t_reg        idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg'(paddr[REG_IDX_LSB]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_ticks  <= QUIET_RESET;
            r_max_attempts <= ATT_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_QUIET_TICKS:  r_quiet_ticks  <= pwdata[15:0];
                REG_MAX_ATTEMPTS: r_max_attempts <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_QUIET_TICKS:  prdata = {16'd0, r_quiet_ticks};
            REG_MAX_ATTEMPTS: prdata = {28'd0, r_max_attempts};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.quiet_ticks  = r_quiet_ticks;
    assign o_cfg.max_attempts = r_max_attempts;

endmodule

// ----- design/lgt_gap_scan.sv -----
// Word-wise search of the presence map for the first missing id of a window.
module lgt_gap_scan #(
    parameter int ID_SPACE = 65536,
    parameter int WORD_W   = 64,
    parameter int DEPTH    = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lgt_pkg::t_scan_req i_req,
    input  logic [WORD_W-1:0]  i_rd_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output lgt_pkg::t_scan_res o_res
);
    import lgt_pkg::*;

    localparam int              WSH       = $clog2(WORD_W);
    localparam logic [16:0]     ID_LIM    = 17'(ID_SPACE);
    localparam logic [AW-1:0]   LAST_WORD = AW'(DEPTH - 1);
    localparam logic [15:0]     LAST_W16  = 16'(DEPTH - 1);
    localparam logic [WSH-1:0]  TOP_BIT   = WSH'(WORD_W - 1);

    logic              r_issue, r_eval, r_done;
    logic              n_issue, n_eval, n_done;
    logic              r_found, n_found;
    logic [15:0]       r_gap, n_gap;
    logic [15:0]       r_lo, r_last;
    logic [AW-1:0]     r_addr, r_end, r_eval_addr;
    logic [AW-1:0]     n_addr, n_end, n_eval_addr;

    logic [15:0]       lo_w16, last_w16, ev_w16, req_lo_w16, req_last_w16;
    logic [WSH-1:0]    lo_bit, last_bit, first_idx;
    logic [WORD_W-1:0] m_lo, m_hi, miss;
    logic              req_lo_out;

    assign lo_w16       = r_lo >> WSH;
    assign last_w16     = r_last >> WSH;
    assign ev_w16       = 16'(r_eval_addr);
    assign lo_bit       = r_lo[WSH-1:0];
    assign last_bit     = r_last[WSH-1:0];
    assign req_lo_w16   = i_req.lo >> WSH;
    assign req_last_w16 = i_req.last >> WSH;
    assign req_lo_out   = {1'b0, i_req.lo} >= ID_LIM;

    always_comb begin
        m_lo = (ev_w16 == lo_w16) ? ({WORD_W{1'b1}} << lo_bit) : {WORD_W{1'b1}};
        m_hi = (ev_w16 == last_w16) ? ({WORD_W{1'b1}} >> (TOP_BIT - last_bit))
                                    : {WORD_W{1'b1}};
        miss = ~i_rd_data & m_lo & m_hi;
        first_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (miss[b]) begin
                first_idx = WSH'(b);
            end
        end
    end

    always_comb begin
        n_issue     = r_issue;
        n_eval      = 1'b0;
        n_done      = 1'b0;
        n_found     = r_found;
        n_gap       = r_gap;
        n_addr      = r_addr;
        n_end       = r_end;
        n_eval_addr = r_eval_addr;
        if (i_req.start) begin
            if (req_lo_out) begin
                n_issue = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b1;
                n_gap   = i_req.lo;
            end else begin
                n_issue = 1'b1;
                n_addr  = req_lo_w16[AW-1:0];
                n_end   = (req_last_w16 > LAST_W16) ? LAST_WORD : req_last_w16[AW-1:0];
            end
        end else begin
            if (r_issue) begin
                n_eval      = 1'b1;
                n_eval_addr = r_addr;
                if (r_addr == r_end) begin
                    n_issue = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            if (r_eval) begin
                if (|miss) begin
                    n_issue = 1'b0;
                    n_eval  = 1'b0;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_gap   = (16'(r_eval_addr) << WSH) | 16'(first_idx);
                end else if (r_eval_addr == r_end) begin
                    n_done  = 1'b1;
                    n_found = {1'b0, r_last} >= ID_LIM;
                    n_gap   = 16'(ID_SPACE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_eval  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_issue <= n_issue;
            r_eval  <= n_eval;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found     <= n_found;
        r_gap       <= n_gap;
        r_addr      <= n_addr;
        r_end       <= n_end;
        r_eval_addr <= n_eval_addr;
        if (i_req.start) begin
            r_lo   <= i_req.lo;
            r_last <= i_req.last;
        end
    end

    assign o_rd_en     = r_issue;
    assign o_rd_addr   = r_addr;
    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.gap   = r_gap;

`include "listing_gap_tracker_core_assert.svh"

    `LGT_ASSERT_IMPL(a_gap_in_window, r_done && r_found, r_gap >= r_lo, "gap below window")
    `LGT_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "scan done held longer than a cycle")
    `LGT_ASSERT_IMPL(a_issue_range, r_issue, r_addr <= r_end, "scan address past end word")

endmodule

// ----- sim/listing_gap_tracker_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for listing_gap_tracker_core: directed table, then random listings.
module listing_gap_tracker_core_test;
    import lgt_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int DIRECTED_ROWS = 27;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 93;
    localparam int DRAIN_CYCLES  = 1100;
    localparam int PHASE_QUIET    [PHASES] = '{2, 1, 3, 0, 65535, 5};
    localparam int PHASE_ATTEMPTS [PHASES] = '{3, 1, 15, 0, 4, 2};
    localparam int PHASE_SEND_IDLE[PHASES] = '{0, 79, 0, 20, 0, 79};
    localparam int PHASE_STALL    [PHASES] = '{0, 0, 79, 20, 79, 0};

    typedef struct packed {
        t_op         op;
        logic [15:0] entry_id;
        logic [15:0] offered_count;
        logic [15:0] offered_last;
    } t_request;

    typedef struct packed {
        t_action     action;
        logic [15:0] request_start;
        logic [3:0]  attempts_used;
    } t_result;

    typedef struct packed {
        logic        reg_write;
        t_reg        reg_sel;
        logic [15:0] reg_value;
        t_request    req;
        logic        typed;
        t_result     want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_op;
    logic [15:0]         i_entry_id;
    logic [15:0]         i_offered_count;
    logic [15:0]         i_offered_last;
    logic                o_valid;
    logic                i_ready;
    logic [2:0]          o_action;
    logic [15:0]         o_request_start;
    logic [3:0]          o_attempts_used;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [REG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    listing_gap_tracker_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_entry_id      (i_entry_id),
        .i_offered_count (i_offered_count),
        .i_offered_last  (i_offered_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_request_start (o_request_start),
        .o_attempts_used (o_attempts_used),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // tracker copy
    bit          seen_ids[int];
    logic [15:0] held_count;
    logic [15:0] held_last;
    bit          got_any;
    bit          running;
    logic [3:0]  attempt_count;
    logic [15:0] quiet_count;
    logic [15:0] retry_from;
    logic [15:0] cfg_quiet = QUIET_RESET;
    logic [3:0]  cfg_attempts = ATT_RESET;

    t_result awaited_results[$];
    int      mismatch_count = 0;
    int      requests_sent = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      cycle_count = 0;
    t_row    directed[DIRECTED_ROWS];

    function automatic bit find_gap(output int gap_id);
        int id;
        for (id = int'(held_last) + 1 - int'(held_count); id <= int'(held_last); id++) begin
            if (!seen_ids.exists(id)) begin
                gap_id = id;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit window_ok();
        return got_any && held_count != 0 && int'(held_last) + 1 >= int'(held_count);
    endfunction

    function automatic bit window_filled();
        int gap_id;
        if (!got_any)
            return 1'b0;
        if (held_count == 0)
            return 1'b1;
        if (int'(held_last) + 1 < int'(held_count))
            return 1'b0;
        return !find_gap(gap_id);
    endfunction

    function automatic t_result predict_result(t_request r);
        t_result res;
        int      gap_id;
        int      limit_q;
        int      limit_a;
        res.action = ACT_NONE;
        res.request_start = '0;
        case (r.op)
            OP_START: begin
                seen_ids.delete();
                held_count = '0;
                held_last = '0;
                got_any = 1'b0;
                running = 1'b1;
                attempt_count = 4'd1;
                quiet_count = '0;
                retry_from = '0;
                res.action = ACT_REQUEST;
            end
            OP_ENTRY: if (running) begin
                held_count = r.offered_count;
                held_last = r.offered_last;
                got_any = 1'b1;
                if (r.offered_count != 0)
                    seen_ids[int'(r.entry_id)] = 1'b1;
                quiet_count = '0;
                if (window_filled()) begin
                    running = 1'b0;
                    res.action = ACT_COMPLETE;
                end
            end
            OP_TICK: if (running) begin
                limit_q = (cfg_quiet == 0) ? 1 : int'(cfg_quiet);
                limit_a = (cfg_attempts == 0) ? 1 : int'(cfg_attempts);
                if (quiet_count != QUIET_SAT)
                    quiet_count = quiet_count + 16'd1;
                if (int'(quiet_count) >= limit_q) begin
                    if (window_ok() && find_gap(gap_id))
                        retry_from = gap_id[15:0];
                    if (int'(attempt_count) < limit_a) begin
                        attempt_count = attempt_count + 4'd1;
                        quiet_count = '0;
                        res.action = ACT_REQUEST;
                        res.request_start = retry_from;
                    end else begin
                        running = 1'b0;
                        res.action = ACT_GAVE_UP;
                    end
                end
            end
            default: if (running) begin
                running = 1'b0;
                res.action = ACT_ABORTED;
            end
        endcase
        res.attempts_used = attempt_count;
        return res;
    endfunction

    function automatic t_request make_request(t_op op, logic [15:0] id, logic [15:0] cnt,
                                              logic [15:0] last);
        t_request r;
        r.op = op;
        r.entry_id = id;
        r.offered_count = cnt;
        r.offered_last = last;
        return r;
    endfunction

    function automatic t_row plain_row(t_op op, logic [15:0] id, logic [15:0] cnt,
                                       logic [15:0] last);
        t_row row;
        row = '0;
        row.req = make_request(op, id, cnt, last);
        return row;
    endfunction

    function automatic t_row typed_row(t_op op, logic [15:0] id, logic [15:0] cnt,
                                       logic [15:0] last, t_action act,
                                       logic [15:0] start, logic [3:0] used);
        t_row row;
        row = plain_row(op, id, cnt, last);
        row.typed = 1'b1;
        row.want.action = act;
        row.want.request_start = start;
        row.want.attempts_used = used;
        return row;
    endfunction

    function automatic t_row cfg_row(t_reg sel, logic [15:0] value);
        t_row row;
        row = '0;
        row.reg_write = 1'b1;
        row.reg_sel = sel;
        row.reg_value = value;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(t_request r, bit typed = 1'b0, t_result want = '0);
        int      gap;
        t_result predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op;
        i_entry_id <= r.entry_id;
        i_offered_count <= r.offered_count;
        i_offered_last <= r.offered_last;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_result(r);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle_idle();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg sel, logic [15:0] value);
        logic [31:0] want;
        want = (sel == REG_QUIET_TICKS) ? {16'd0, value} : {28'd0, value[3:0]};
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_AW'(int'(sel) << REG_IDX_LSB);
        pwdata <= want;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_QUIET_TICKS)
            cfg_quiet = value;
        else
            cfg_attempts = value[3:0];
    endtask

    task automatic tick_burst();
        repeat ($urandom_range(4, 1))
            push_request(make_request(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // start, one pass with holes, ticks or a stop, then a pass with no holes, then ticks
    task automatic run_listing();
        int          roll;
        int          cnt;
        int          last;
        int          lo;
        int          span;
        int          offset;
        int          j;
        bit          broken;
        logic [15:0] id;
        roll = $urandom_range(99);
        if (roll < 8)
            cnt = 0;
        else if (roll < 14)
            cnt = $urandom_range(65535, 64);
        else
            cnt = $urandom_range(12, 1);
        broken = (cnt > 1) && ($urandom_range(99) < 8);
        if (broken)
            last = $urandom_range(cnt - 2, 0);
        else
            last = $urandom_range(65535, (cnt > 0) ? cnt - 1 : 0);
        lo = last + 1 - cnt;
        span = (cnt > 16) ? 6 : ((cnt > 0) ? cnt : 1);
        offset = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
        push_request(make_request(OP_START, 16'($urandom), 16'($urandom), 16'($urandom)));
        for (int round = 0; round < 2; round++) begin
            for (j = 0; j < span; j++) begin
                if ($urandom_range(99) < 15)
                    tick_burst();
                if (round == 0 && $urandom_range(99) < 12)
                    continue;
                if (broken || cnt == 0 || $urandom_range(99) < 5)
                    id = 16'($urandom);
                else
                    id = 16'(lo + (offset + j) % cnt);
                push_request(make_request(OP_ENTRY, id, 16'(cnt), 16'(last)));
            end
            if (round == 0 && $urandom_range(99) < 10) begin
                push_request(make_request(OP_STOP, 16'($urandom), 16'($urandom),
                                          16'($urandom)));
                return;
            end
            tick_burst();
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, action", 32'(o_action), 32'd0);
            end else begin
                want = awaited_results.pop_front();
                if (o_action !== want.action)
                    report_mismatch("action", 32'(o_action), 32'(want.action));
                if (o_request_start !== want.request_start)
                    report_mismatch("request_start", 32'(o_request_start),
                                    32'(want.request_start));
                if (o_attempts_used !== want.attempts_used)
                    report_mismatch("attempts_used", 32'(o_attempts_used),
                                    32'(want.attempts_used));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase_end;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_START;
        i_entry_id = '0;
        i_offered_count = '0;
        i_offered_last = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        directed = '{
            typed_row(OP_STOP,  16'd0,     16'd0,     16'd0,     ACT_NONE,     16'd0, 4'd0),
            typed_row(OP_TICK,  16'd0,     16'd0,     16'd0,     ACT_NONE,     16'd0, 4'd0),
            typed_row(OP_ENTRY, 16'd5,     16'd3,     16'd7,     ACT_NONE,     16'd0, 4'd0),
            cfg_row(REG_QUIET_TICKS, 16'd1),
            cfg_row(REG_MAX_ATTEMPTS, 16'd2),
            typed_row(OP_START, 16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd1),
            typed_row(OP_TICK,  16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd2),
            typed_row(OP_TICK,  16'd0,     16'd0,     16'd0,     ACT_GAVE_UP,  16'd0, 4'd2),
            typed_row(OP_START, 16'hFFFF,  16'hFFFF,  16'hFFFF,  ACT_REQUEST,  16'd0, 4'd1),
            plain_row(OP_ENTRY, 16'hFFFF,  16'hFFFF,  16'hFFFF),
            plain_row(OP_TICK,  16'hFFFF,  16'hFFFF,  16'hFFFF),
            typed_row(OP_ENTRY, 16'd0,     16'd0,     16'd0,     ACT_COMPLETE, 16'd0, 4'd2),
            typed_row(OP_START, 16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd1),
            typed_row(OP_ENTRY, 16'd3,     16'd5,     16'd2,     ACT_NONE,     16'd0, 4'd1),
            typed_row(OP_TICK,  16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd2),
            typed_row(OP_STOP,  16'd0,     16'd0,     16'd0,     ACT_ABORTED,  16'd0, 4'd2),
            cfg_row(REG_QUIET_TICKS, 16'd0),
            cfg_row(REG_MAX_ATTEMPTS, 16'd0),
            typed_row(OP_START, 16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd1),
            plain_row(OP_ENTRY, 16'd10,    16'd2,     16'd11),
            typed_row(OP_TICK,  16'd0,     16'd0,     16'd0,     ACT_GAVE_UP,  16'd0, 4'd1),
            cfg_row(REG_MAX_ATTEMPTS, 16'd15),
            cfg_row(REG_QUIET_TICKS, 16'hFFFF),
            typed_row(OP_START, 16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd1),
            typed_row(OP_START, 16'd0,     16'd0,     16'd0,     ACT_REQUEST,  16'd0, 4'd1),
            typed_row(OP_ENTRY, 16'hFFFF,  16'd1,     16'hFFFF,  ACT_COMPLETE, 16'd0, 4'd1),
            plain_row(OP_ENTRY, 16'd0,     16'd1,     16'd0)
        };
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].reg_write) begin
                settle_idle();
                write_register(directed[i].reg_sel, directed[i].reg_value);
            end else begin
                push_request(directed[i].req, directed[i].typed, directed[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            write_register(REG_QUIET_TICKS, 16'(PHASE_QUIET[p]));
            write_register(REG_MAX_ATTEMPTS, 16'(PHASE_ATTEMPTS[p]));
            send_idle_pct = PHASE_SEND_IDLE[p];
            stall_pct = PHASE_STALL[p];
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end) begin
                if ($urandom_range(99) < 3)
                    settle_idle();
                if ($urandom_range(99) < 10)
                    push_request(make_request(t_op'($urandom_range(3)), 16'($urandom),
                                              16'($urandom), 16'($urandom)));
                else
                    run_listing();
            end
        end

        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
